>>> hw/rtl/calu_pkg.sv
// Shared types, operation codes and constants of the flag-producing CPU ALU.
package calu_pkg;

   // operation codes carried in the request tuser
   localparam logic [4:0] FUNC_ADD   = 5'd0;
   localparam logic [4:0] FUNC_ADC   = 5'd1;
   localparam logic [4:0] FUNC_SUB   = 5'd2;
   localparam logic [4:0] FUNC_SBC   = 5'd3;
   localparam logic [4:0] FUNC_AND   = 5'd4;
   localparam logic [4:0] FUNC_XOR   = 5'd5;
   localparam logic [4:0] FUNC_OR    = 5'd6;
   localparam logic [4:0] FUNC_CP    = 5'd7;
   localparam logic [4:0] FUNC_INC   = 5'd8;
   localparam logic [4:0] FUNC_DEC   = 5'd9;
   localparam logic [4:0] FUNC_DAA   = 5'd10;
   localparam logic [4:0] FUNC_CPL   = 5'd11;
   localparam logic [4:0] FUNC_CCF   = 5'd12;
   localparam logic [4:0] FUNC_SCF   = 5'd13;
   localparam logic [4:0] FUNC_RLC   = 5'd14;
   localparam logic [4:0] FUNC_RRC   = 5'd15;
   localparam logic [4:0] FUNC_RL    = 5'd16;
   localparam logic [4:0] FUNC_RR    = 5'd17;
   localparam logic [4:0] FUNC_SLA   = 5'd18;
   localparam logic [4:0] FUNC_SRA   = 5'd19;
   localparam logic [4:0] FUNC_SRL   = 5'd20;
   localparam logic [4:0] FUNC_SWAP  = 5'd21;
   localparam logic [4:0] FUNC_BIT   = 5'd22;
   localparam logic [4:0] FUNC_SET   = 5'd23;
   localparam logic [4:0] FUNC_RES   = 5'd24;
   localparam logic [4:0] FUNC_ADD16 = 5'd25;
   localparam logic [4:0] FUNC_SPOFF = 5'd26;
   localparam logic [4:0] FUNC_INC16 = 5'd27;
   localparam logic [4:0] FUNC_DEC16 = 5'd28;

   // flag bit positions
   localparam int FLAG_Z = 3;
   localparam int FLAG_N = 2;
   localparam int FLAG_H = 1;
   localparam int FLAG_C = 0;

   // decimal adjust constants
   localparam logic [7:0] DAA_HI_ADJ  = 8'h60;
   localparam logic [7:0] DAA_LO_ADJ  = 8'h06;
   localparam logic [7:0] DAA_HI_LIM  = 8'h99;
   localparam logic [3:0] DAA_LO_LIM  = 4'h9;

   // widths of the packed stream words
   localparam int REQ_TDATA_W = 48;
   localparam int REQ_TUSER_W = 5;
   localparam int RSP_TDATA_W = 24;

   typedef struct packed {
      logic [4:0]        func;
      logic [15:0]       operand_a;
      logic [15:0]       operand_b;
      logic signed [7:0] signed_offset;
      logic [2:0]        bit_index;
      logic [3:0]        flags_in;
   } calu_req_type;

   typedef struct packed {
      logic [15:0] result;
      logic [3:0]  flags_out;
   } calu_rsp_type;

endpackage

>>> hw/rtl/calu_pipe.sv
// One valid/ready register stage that holds a word until the next side takes it.
module calu_pipe #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);

   logic             valid_ff, valid_in;
   logic [WIDTH-1:0] data_ff;

   // take a new word when empty or when the held word leaves this cycle
   assign in_ready = !valid_ff || out_ready;
   assign valid_in = in_ready ? in_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // load the payload on every accepted word
   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

>>> hw/rtl/calu_exec.sv
// Combinational datapath: result and flags for one ALU operation.
module calu_exec (
   input  calu_pkg::calu_req_type req,
   output calu_pkg::calu_rsp_type rsp
);

   logic [7:0]  a, b, r8, mask, daa_val;
   logic        fz, fn, fh, fc, cin, daa_c;
   logic [8:0]  add9, sub9;
   logic [4:0]  addh, subh;
   logic [16:0] add17;
   logic [12:0] add13;
   logic [4:0]  sph;
   logic [8:0]  spc;
   logic [15:0] sp_sum;
   logic [15:0] r16;
   logic [3:0]  nf;

   // split the operands and incoming flags
   assign a   = req.operand_a[7:0];
   assign b   = req.operand_b[7:0];
   assign fz  = req.flags_in[calu_pkg::FLAG_Z];
   assign fn  = req.flags_in[calu_pkg::FLAG_N];
   assign fh  = req.flags_in[calu_pkg::FLAG_H];
   assign fc  = req.flags_in[calu_pkg::FLAG_C];
   assign cin = ((req.func == calu_pkg::FUNC_ADC) || (req.func == calu_pkg::FUNC_SBC)) && fc;

   // byte add and subtract with nibble carries
   assign add9 = {1'b0, a} + {1'b0, b} + {8'd0, cin};
   assign addh = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, cin};
   assign sub9 = {1'b0, a} - {1'b0, b} - {8'd0, cin};
   assign subh = {1'b0, a[3:0]} - {1'b0, b[3:0]} - {4'd0, cin};

   // pair add with carries out of bits 11 and 15
   assign add17 = {1'b0, req.operand_a} + {1'b0, req.operand_b};
   assign add13 = {1'b0, req.operand_a[11:0]} + {1'b0, req.operand_b[11:0]};

   // stack pointer plus sign-extended offset; flags from the low byte
   assign sp_sum = req.operand_a + 16'(req.signed_offset);
   assign sph    = {1'b0, req.operand_a[3:0]} + {1'b0, req.signed_offset[3:0]};
   assign spc    = {1'b0, req.operand_a[7:0]} + {1'b0, req.signed_offset[7:0]};

   assign mask = 8'd1 << req.bit_index;

   // decimal adjust after add or subtract
   always_comb begin
      daa_val = a;
      daa_c   = fc;
      if (fn) begin
         if (fc) daa_val = daa_val - calu_pkg::DAA_HI_ADJ;
         if (fh) daa_val = daa_val - calu_pkg::DAA_LO_ADJ;
      end else begin
         if (fc || (a > calu_pkg::DAA_HI_LIM)) begin
            daa_val = daa_val + calu_pkg::DAA_HI_ADJ;
            daa_c   = 1'b1;
         end
         if (fh || (a[3:0] > calu_pkg::DAA_LO_LIM)) daa_val = daa_val + calu_pkg::DAA_LO_ADJ;
      end
   end

   // select result and flags by operation
   always_comb begin
      r8  = 8'd0;
      r16 = req.operand_a;
      nf  = req.flags_in;
      unique case (req.func)
         calu_pkg::FUNC_ADD, calu_pkg::FUNC_ADC: begin
            r8  = add9[7:0];
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, 1'b0, addh[4], add9[8]};
         end
         calu_pkg::FUNC_SUB, calu_pkg::FUNC_SBC: begin
            r8  = sub9[7:0];
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, 1'b1, subh[4], sub9[8]};
         end
         calu_pkg::FUNC_CP: begin
            nf  = {sub9[7:0] == 8'd0, 1'b1, subh[4], sub9[8]};
         end
         calu_pkg::FUNC_AND: begin
            r8  = a & b;
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, 1'b0, 1'b1, 1'b0};
         end
         calu_pkg::FUNC_XOR: begin
            r8  = a ^ b;
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, 3'b000};
         end
         calu_pkg::FUNC_OR: begin
            r8  = a | b;
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, 3'b000};
         end
         calu_pkg::FUNC_INC: begin
            r8  = a + 8'd1;
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, 1'b0, a[3:0] == 4'hF, fc};
         end
         calu_pkg::FUNC_DEC: begin
            r8  = a - 8'd1;
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, 1'b1, a[3:0] == 4'h0, fc};
         end
         calu_pkg::FUNC_DAA: begin
            r8  = daa_val;
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, fn, 1'b0, daa_c};
         end
         calu_pkg::FUNC_CPL: begin
            r8  = ~a;
            r16 = {8'd0, r8};
            nf  = {fz, 1'b1, 1'b1, fc};
         end
         calu_pkg::FUNC_CCF: nf = {fz, 1'b0, 1'b0, !fc};
         calu_pkg::FUNC_SCF: nf = {fz, 1'b0, 1'b0, 1'b1};
         calu_pkg::FUNC_RLC: begin
            r8  = {a[6:0], a[7]};
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, 1'b0, 1'b0, a[7]};
         end
         calu_pkg::FUNC_RRC: begin
            r8  = {a[0], a[7:1]};
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, 1'b0, 1'b0, a[0]};
         end
         calu_pkg::FUNC_RL: begin
            r8  = {a[6:0], fc};
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, 1'b0, 1'b0, a[7]};
         end
         calu_pkg::FUNC_RR: begin
            r8  = {fc, a[7:1]};
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, 1'b0, 1'b0, a[0]};
         end
         calu_pkg::FUNC_SLA: begin
            r8  = {a[6:0], 1'b0};
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, 1'b0, 1'b0, a[7]};
         end
         calu_pkg::FUNC_SRA: begin
            r8  = {a[7], a[7:1]};
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, 1'b0, 1'b0, a[0]};
         end
         calu_pkg::FUNC_SRL: begin
            r8  = {1'b0, a[7:1]};
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, 1'b0, 1'b0, a[0]};
         end
         calu_pkg::FUNC_SWAP: begin
            r8  = {a[3:0], a[7:4]};
            r16 = {8'd0, r8};
            nf  = {r8 == 8'd0, 3'b000};
         end
         calu_pkg::FUNC_BIT: begin
            nf  = {(a & mask) == 8'd0, 1'b0, 1'b1, fc};
         end
         calu_pkg::FUNC_SET: begin
            r8  = a | mask;
            r16 = {8'd0, r8};
         end
         calu_pkg::FUNC_RES: begin
            r8  = a & ~mask;
            r16 = {8'd0, r8};
         end
         calu_pkg::FUNC_ADD16: begin
            r16 = add17[15:0];
            nf  = {fz, 1'b0, add13[12], add17[16]};
         end
         calu_pkg::FUNC_SPOFF: begin
            r16 = sp_sum;
            nf  = {1'b0, 1'b0, sph[4], spc[8]};
         end
         calu_pkg::FUNC_INC16: r16 = req.operand_a + 16'd1;
         calu_pkg::FUNC_DEC16: r16 = req.operand_a - 16'd1;
         default: begin
            r16 = req.operand_a;
            nf  = req.flags_in;
         end
      endcase
   end

   assign rsp.result    = r16;
   assign rsp.flags_out = nf;

endmodule

>>> hw/rtl/cpu_alu_with_flags.sv
// Top level of the flag-producing CPU ALU: input register, datapath, result register.
// Each accepted request word passes through the input register and the result register to its response word.
// Throughput: one word per cycle; the two register stages pass words on whenever
// the next side is free, and the datapath between them is one short add or logic step.
// Reset: synchronous, active high; it clears both stage valid bits, no other state.
module cpu_alu_with_flags (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // tdata: operand_a[15:0], operand_b[31:16], signed_offset[39:32],
   //        bit_index[42:40], flags_in[46:43], zero[47]
   input  logic [calu_pkg::REQ_TDATA_W-1:0] req_tdata,
   // tuser: func[4:0]
   input  logic [calu_pkg::REQ_TUSER_W-1:0] req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // tdata: result[15:0], flags_out[19:16], zero[23:20]
   output logic [calu_pkg::RSP_TDATA_W-1:0] rsp_tdata
);

   localparam int REQ_W = $bits(calu_pkg::calu_req_type);
   localparam int RSP_W = $bits(calu_pkg::calu_rsp_type);

   calu_pkg::calu_req_type req_word, s1_word;
   calu_pkg::calu_rsp_type s1_rsp, s2_word;
   logic [REQ_W-1:0] s1_bits;
   logic [RSP_W-1:0] s2_bits;
   logic             s1_valid, s1_ready;

   // unpack the request word
   assign req_word.func          = req_tuser;
   assign req_word.operand_a     = req_tdata[15:0];
   assign req_word.operand_b     = req_tdata[31:16];
   assign req_word.signed_offset = req_tdata[39:32];
   assign req_word.bit_index     = req_tdata[42:40];
   assign req_word.flags_in      = req_tdata[46:43];

   // input register
   calu_pipe #(.WIDTH(REQ_W)) u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_word),
      .out_valid (s1_valid),
      .out_ready (s1_ready),
      .out_data  (s1_bits)
   );

   assign s1_word = calu_pkg::calu_req_type'(s1_bits);

   // compute result and flags
   calu_exec u_exec (
      .req (s1_word),
      .rsp (s1_rsp)
   );

   // result register
   calu_pipe #(.WIDTH(RSP_W)) u_out_stage (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (s1_valid),
      .in_ready  (s1_ready),
      .in_data   (s1_rsp),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (s2_bits)
   );

   assign s2_word   = calu_pkg::calu_rsp_type'(s2_bits);
   assign rsp_tdata = {4'd0, s2_word.flags_out, s2_word.result};

   // no response is offered right after a reset cycle
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // an accepted request word is held in the input stage next cycle
   a_accept_lands: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> s1_valid)
      else $error("accepted request lost");

   // with both stages full and the output stalled, no new request is taken
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      s1_valid && rsp_tvalid && !rsp_tready |-> !req_tready)
      else $error("request taken while pipeline full");

   // a stalled input stage keeps its word while the result is pending
   a_s1_hold: assert property (@(posedge clock) disable iff (reset)
      s1_valid && !s1_ready |=> s1_valid && $stable(s1_bits))
      else $error("input stage changed while stalled");

endmodule

>>> test/calu_scoreboard_pkg.sv
// Scoreboard for the flag-producing CPU ALU: per-word prediction and ordered response check.
package calu_scoreboard_pkg;
   import calu_pkg::*;

   // one accepted request and the response it must produce
   typedef struct {
      calu_req_type req;
      calu_rsp_type rsp;
   } alu_case_type;

   class alu_scoreboard;
      alu_case_type pending_q[$];
      int unsigned  error_count;
      int unsigned  request_count;
      int unsigned  response_count;
      int unsigned  func_hits[32];

      function new();
         error_count    = 0;
         request_count  = 0;
         response_count = 0;
         foreach (func_hits[i]) func_hits[i] = 0;
      endfunction

      static function logic [3:0] pack_flags(logic z, logic n, logic h, logic c);
         return {z, n, h, c};
      endfunction

      // Work out result and flags of one operation; untouched flags pass through.
      static function calu_rsp_type compute_alu(calu_req_type q);
         calu_rsp_type e;
         logic [7:0]   a, b, r8;
         logic [3:0]   f;
         logic         cin, dc;
         logic [4:0]   s5;
         logic [8:0]   s9;
         logic [12:0]  s13;
         logic [16:0]  s17;
         a = q.operand_a[7:0];
         b = q.operand_b[7:0];
         f = q.flags_in;
         cin = f[FLAG_C];
         e.result    = q.operand_a;
         e.flags_out = f;
         case (q.func)
            FUNC_ADD, FUNC_ADC: begin
               dc  = (q.func == FUNC_ADC) ? cin : 1'b0;
               s9  = {1'b0, a} + {1'b0, b} + {8'd0, dc};
               s5  = {1'b0, a[3:0]} + {1'b0, b[3:0]} + {4'd0, dc};
               e.result    = {8'h00, s9[7:0]};
               e.flags_out = pack_flags(s9[7:0] == 8'h00, 1'b0, s5[4], s9[8]);
            end
            FUNC_SUB, FUNC_SBC, FUNC_CP: begin
               dc = (q.func == FUNC_SBC) ? cin : 1'b0;
               r8 = a - b - {7'd0, dc};
               e.flags_out = pack_flags(r8 == 8'h00, 1'b1,
                                        {1'b0, a[3:0]} < {1'b0, b[3:0]} + {4'd0, dc},
                                        {1'b0, a} < {1'b0, b} + {8'd0, dc});
               if (q.func != FUNC_CP) e.result = {8'h00, r8};
            end
            FUNC_AND: begin
               r8 = a & b;
               e.result    = {8'h00, r8};
               e.flags_out = pack_flags(r8 == 8'h00, 1'b0, 1'b1, 1'b0);
            end
            FUNC_XOR, FUNC_OR: begin
               r8 = (q.func == FUNC_XOR) ? (a ^ b) : (a | b);
               e.result    = {8'h00, r8};
               e.flags_out = pack_flags(r8 == 8'h00, 1'b0, 1'b0, 1'b0);
            end
            FUNC_INC: begin
               r8 = a + 8'd1;
               e.result    = {8'h00, r8};
               e.flags_out = pack_flags(r8 == 8'h00, 1'b0, a[3:0] == 4'hF, cin);
            end
            FUNC_DEC: begin
               r8 = a - 8'd1;
               e.result    = {8'h00, r8};
               e.flags_out = pack_flags(r8 == 8'h00, 1'b1, a[3:0] == 4'h0, cin);
            end
            FUNC_DAA: begin
               // after subtract only undo what H and C report; after add also check ranges
               r8 = a;
               dc = cin;
               if (f[FLAG_N]) begin
                  if (cin) r8 = r8 - DAA_HI_ADJ;
                  if (f[FLAG_H]) r8 = r8 - DAA_LO_ADJ;
               end else begin
                  if (cin || a > DAA_HI_LIM) begin
                     r8 = r8 + DAA_HI_ADJ;
                     dc = 1'b1;
                  end
                  if (f[FLAG_H] || a[3:0] > DAA_LO_LIM) r8 = r8 + DAA_LO_ADJ;
               end
               e.result    = {8'h00, r8};
               e.flags_out = pack_flags(r8 == 8'h00, f[FLAG_N], 1'b0, dc);
            end
            FUNC_CPL: begin
               e.result    = {8'h00, ~a};
               e.flags_out = pack_flags(f[FLAG_Z], 1'b1, 1'b1, cin);
            end
            FUNC_CCF: e.flags_out = pack_flags(f[FLAG_Z], 1'b0, 1'b0, ~cin);
            FUNC_SCF: e.flags_out = pack_flags(f[FLAG_Z], 1'b0, 1'b0, 1'b1);
            FUNC_RLC, FUNC_RRC, FUNC_RL, FUNC_RR, FUNC_SLA, FUNC_SRA, FUNC_SRL,
            FUNC_SWAP: begin
               // shifts out of the top set C from bit 7, the other shifts from bit 0; SWAP clears C
               case (q.func)
                  FUNC_RLC: r8 = {a[6:0], a[7]};
                  FUNC_RRC: r8 = {a[0], a[7:1]};
                  FUNC_RL:  r8 = {a[6:0], cin};
                  FUNC_RR:  r8 = {cin, a[7:1]};
                  FUNC_SLA: r8 = {a[6:0], 1'b0};
                  FUNC_SRA: r8 = {a[7], a[7:1]};
                  FUNC_SRL: r8 = {1'b0, a[7:1]};
                  default:  r8 = {a[3:0], a[7:4]};
               endcase
               if (q.func == FUNC_SWAP) dc = 1'b0;
               else if (q.func == FUNC_RLC || q.func == FUNC_RL || q.func == FUNC_SLA)
                  dc = a[7];
               else dc = a[0];
               e.result    = {8'h00, r8};
               e.flags_out = pack_flags(r8 == 8'h00, 1'b0, 1'b0, dc);
            end
            FUNC_BIT: e.flags_out = pack_flags(~a[q.bit_index], 1'b0, 1'b1, cin);
            FUNC_SET: e.result = {8'h00, a | (8'd1 << q.bit_index)};
            FUNC_RES: e.result = {8'h00, a & ~(8'd1 << q.bit_index)};
            FUNC_ADD16: begin
               s17 = {1'b0, q.operand_a} + {1'b0, q.operand_b};
               s13 = {1'b0, q.operand_a[11:0]} + {1'b0, q.operand_b[11:0]};
               e.result    = s17[15:0];
               e.flags_out = pack_flags(f[FLAG_Z], 1'b0, s13[12], s17[16]);
            end
            FUNC_SPOFF: begin
               // carries come from the unsigned low nibble and low byte sums
               s5 = {1'b0, q.operand_a[3:0]} + {1'b0, q.signed_offset[3:0]};
               s9 = {1'b0, q.operand_a[7:0]} + {1'b0, q.signed_offset[7:0]};
               e.result    = q.operand_a + {{8{q.signed_offset[7]}}, q.signed_offset};
               e.flags_out = pack_flags(1'b0, 1'b0, s5[4], s9[8]);
            end
            FUNC_INC16: e.result = q.operand_a + 16'd1;
            FUNC_DEC16: e.result = q.operand_a - 16'd1;
            default: ;
         endcase
         return e;
      endfunction

      function void note_request(calu_req_type q);
         alu_case_type c;
         c.req = q;
         c.rsp = compute_alu(q);
         pending_q.push_back(c);
         request_count++;
         func_hits[q.func]++;
      endfunction

      task report_mismatch(string what);
         error_count++;
         $display("mismatch at response %0d: %s", response_count, what);
      endtask

      // Compare one response word with the oldest pending request.
      task check_response(logic [RSP_TDATA_W-1:0] word);
         alu_case_type c;
         response_count++;
         if (pending_q.size() == 0) begin
            report_mismatch($sformatf("unexpected word %h", word));
            return;
         end
         c = pending_q.pop_front();
         if (word[15:0] !== c.rsp.result)
            report_mismatch($sformatf("func %0d a %h b %h off %h bit %0d f %h: result %h, want %h",
               c.req.func, c.req.operand_a, c.req.operand_b, c.req.signed_offset,
               c.req.bit_index, c.req.flags_in, word[15:0], c.rsp.result));
         if (word[19:16] !== c.rsp.flags_out)
            report_mismatch($sformatf("func %0d a %h b %h off %h bit %0d f %h: flags %b, want %b",
               c.req.func, c.req.operand_a, c.req.operand_b, c.req.signed_offset,
               c.req.bit_index, c.req.flags_in, word[19:16], c.rsp.flags_out));
      endtask

      task finish_check();
         if (pending_q.size() != 0)
            report_mismatch($sformatf("%0d responses never arrived", pending_q.size()));
      endtask
   endclass

endpackage

>>> test/testbench.sv
// Stream testbench for the flag-producing CPU ALU: directed and random words, random stalls.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import calu_pkg::*;
   import calu_scoreboard_pkg::*;

   localparam int          RESET_CYCLES  = 10;
   localparam int          RANDOM_WORDS  = 1100;
   localparam int          CALM_FIRST    = 300;
   localparam int          CALM_LAST     = 500;
   localparam int          HOLD_AFTER    = 700;
   localparam int          HOLD_CYCLES   = 80;
   localparam int          DRAIN_CYCLES  = 8;
   localparam int          STALL_LIMIT   = 1000;
   localparam int          IDLE_PERCENT  = 37;
   localparam logic [4:0]  FUNC_TOP      = '1;
   localparam logic [15:0] CORNER_WORDS [8] = '{16'h0000, 16'hFFFF, 16'h00FF, 16'hFF00,
                                               16'h0FFF, 16'h8000, 16'h000F, 16'h0080};

   logic                   clock      = 1'b0;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [REQ_TUSER_W-1:0] req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   // no idle cycles on either side while set
   bit                     calm = 1'b0;
   alu_scoreboard          sb = new();

   cpu_alu_with_flags u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic [15:0] pick_word();
      if ($urandom_range(0, 7) == 0) return CORNER_WORDS[$urandom_range(0, 7)];
      return 16'($urandom());
   endfunction

   function automatic calu_req_type random_request();
      calu_req_type q;
      if ($urandom_range(0, 19) == 0) q.func = 5'($urandom_range(FUNC_DEC16 + 1, FUNC_TOP));
      else q.func = 5'($urandom_range(0, FUNC_DEC16));
      q.operand_a     = pick_word();
      q.operand_b     = pick_word();
      q.signed_offset = 8'($urandom());
      q.bit_index     = 3'($urandom());
      q.flags_in      = 4'($urandom());
      return q;
   endfunction

   // Offer one word after random idle cycles; return at the edge that takes it.
   task automatic send_request(input calu_req_type q);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= q.func;
      req_tdata  <= {1'b0, q.flags_in, q.bit_index, q.signed_offset, q.operand_b, q.operand_a};
      do @(posedge clock); while (!req_tready);
      sb.note_request(q);
   endtask

   task automatic send_directed(input logic [4:0] func, input logic [15:0] a,
                                input logic [15:0] b, input logic [7:0] off,
                                input logic [2:0] bidx, input logic [3:0] flags);
      calu_req_type q;
      q.func          = func;
      q.operand_a     = a;
      q.operand_b     = b;
      q.signed_offset = off;
      q.bit_index     = bidx;
      q.flags_in      = flags;
      send_request(q);
   endtask

   // Receive side: check each taken word, stall at random, hold off once for long.
   initial begin : response_side
      int unsigned hold_left;
      bit          hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) sb.check_response(rsp_tdata);
         if (!hold_done && sb.response_count >= HOLD_AFTER) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
         end
      end
   end

   // Abort when no word moves on either side for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("watchdog: no word moved in %0d cycles", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : request_side
      int unsigned covered;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // sweep every code, spare ones included, with corner operands and flags
      for (int i = 0; i <= FUNC_TOP; i++)
         send_directed(5'(i), CORNER_WORDS[i % 8], CORNER_WORDS[(i + 3) % 8],
                       i[0] ? 8'h80 : 8'h7F, 3'(i), 4'(i));
      // decimal adjust after subtract and after add past both limits
      send_directed(FUNC_DAA, 16'h009A, 16'h0000, 8'h00, 3'd0, 4'b0111);
      send_directed(FUNC_DAA, 16'h009A, 16'h0000, 8'h00, 3'd0, 4'b0000);
      // pair add carrying out of bit 11, stack offset of minus one and plus one
      send_directed(FUNC_ADD16, 16'h0FFF, 16'h0001, 8'h00, 3'd0, 4'b1000);
      send_directed(FUNC_SPOFF, 16'h00FF, 16'h0000, 8'hFF, 3'd0, 4'b1111);
      send_directed(FUNC_SPOFF, 16'hFFFF, 16'h0000, 8'h01, 3'd0, 4'b0000);
      // subtract to zero, add with carry wrapping
      send_directed(FUNC_SUB, 16'h1234, 16'h5634, 8'h00, 3'd0, 4'b0000);
      send_directed(FUNC_ADC, 16'h00FF, 16'h0000, 8'h00, 3'd0, 4'b0001);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         calm = (n >= CALM_FIRST && n < CALM_LAST);
         send_request(random_request());
      end
      calm = 1'b0;
      req_tvalid <= 1'b0;

      // drain, then give a stray word time to show up
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      sb.finish_check();

      covered = 0;
      foreach (sb.func_hits[i]) if (sb.func_hits[i] != 0) covered++;
      $display("run: %0d requests, %0d responses checked, %0d of 32 operation codes used",
               sb.request_count, sb.response_count, covered);
      $display("run: random stalls on both sides, one idle-free stretch, one %0d-cycle hold-off",
               HOLD_CYCLES);
      if (sb.error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
